// ----- hdl/ortest_pkg.sv -----
// ---------------------------------------------------------------------------
// Oriented rectangle overlap test: shared definitions
// Widths, corner field order, lane pipeline stages and shared types.
// ---------------------------------------------------------------------------
`default_nettype none

package ortest_pkg;

    localparam int CW    = 16;
    localparam int FW    = 16;
    localparam int NF    = 8;
    localparam int AW    = CW + 1;
    localparam int PW    = CW + AW;
    localparam int DW    = PW + 1;
    localparam int NLANE = 4;
    localparam int NLS   = 5;
    localparam int TDW   = NF * FW;
    localparam int OTW   = 8;

    localparam int LT_X = 0;
    localparam int LT_Y = 1;
    localparam int RT_X = 2;
    localparam int RT_Y = 3;
    localparam int RB_X = 4;
    localparam int RB_Y = 5;

    localparam int ST_MUL  = 0;
    localparam int ST_DOT  = 1;
    localparam int ST_PAIR = 2;
    localparam int ST_RED  = 3;
    localparam int ST_CMP  = 4;

    typedef logic [NF-1:0][CW-1:0] t_rect;

    typedef struct packed {
        logic signed [AW-1:0] x;
        logic signed [AW-1:0] y;
    } t_axis;

    typedef struct packed {
        logic [NLS-1:0] en;
    } t_lane_ctrl;

    function automatic logic [CW-1:0] to_coord(input logic [FW-1:0] f);
        logic [CW+FW-1:0] t;
        t = {{CW{1'b0}}, f};
        return t[CW-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/oriented_rect_overlap_test_top.sv -----
// ---------------------------------------------------------------------------
// Oriented rectangle overlap test: top level
// Separating-axis test of a rectangle against a stored reference rectangle.
// ---------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         tuser = test, tdata = lt_x..lb_y (16 bits each)
// m_axis    out        tdata[0] = hit, tdata[7:1] = 0
//
// One transfer is accepted per cycle while tready is high; four axis lanes run side by side.
// A test result passes through the input stage, which loads at the accepting
// edge, then five lane stages (multiply, dot sum, pair min/max, reduce,
// compare), then the output register.
// A store transfer updates the reference at once and gives no result.
// Reset clears all valid bits and sets the reference rectangle to zero.
// An output stall backs up stage by stage; empty stages keep filling.
// ---------------------------------------------------------------------------
`default_nettype none

module oriented_rect_overlap_test_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // lt_x, lt_y, rt_x, rt_y, rb_x, rb_y, lb_x, lb_y
    input  wire logic [ortest_pkg::TDW-1:0]   i_s_axis_tdata,
    // test
    input  wire logic [0:0]                   i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  wire logic                         i_m_axis_tready,
    // hit, zero fill
    output logic [ortest_pkg::OTW-1:0]        o_m_axis_tdata
);

    ortest_pkg::t_rect                   cur;
    ortest_pkg::t_axis                   ax [ortest_pkg::NLANE];
    logic                                accept;
    logic                                take;
    logic                                en_a;
    logic [ortest_pkg::NLS-1:0]          en_l;
    ortest_pkg::t_lane_ctrl              ctrl;
    logic [ortest_pkg::NLANE-1:0]        lane_hit;

    ortest_pkg::t_rect                   r_ref;
    ortest_pkg::t_rect                   r_a_ref;
    ortest_pkg::t_rect                   r_a_cur;
    ortest_pkg::t_axis                   r_a_axis [ortest_pkg::NLANE];
    logic                                r_va;
    logic [ortest_pkg::NLS-1:0]          r_vl;

    always_comb begin
        for (int j = 0; j < ortest_pkg::NF; j++) begin
            cur[j] = ortest_pkg::to_coord(i_s_axis_tdata[j*ortest_pkg::FW +: ortest_pkg::FW]);
        end
    end

    always_comb begin
        ax[0].x = ortest_pkg::AW'($signed(r_ref[ortest_pkg::RT_X]))
                - ortest_pkg::AW'($signed(r_ref[ortest_pkg::LT_X]));
        ax[0].y = ortest_pkg::AW'($signed(r_ref[ortest_pkg::RT_Y]))
                - ortest_pkg::AW'($signed(r_ref[ortest_pkg::LT_Y]));
        ax[1].x = ortest_pkg::AW'($signed(r_ref[ortest_pkg::RB_X]))
                - ortest_pkg::AW'($signed(r_ref[ortest_pkg::RT_X]));
        ax[1].y = ortest_pkg::AW'($signed(r_ref[ortest_pkg::RB_Y]))
                - ortest_pkg::AW'($signed(r_ref[ortest_pkg::RT_Y]));
        ax[2].x = ortest_pkg::AW'($signed(cur[ortest_pkg::RT_X]))
                - ortest_pkg::AW'($signed(cur[ortest_pkg::LT_X]));
        ax[2].y = ortest_pkg::AW'($signed(cur[ortest_pkg::RT_Y]))
                - ortest_pkg::AW'($signed(cur[ortest_pkg::LT_Y]));
        ax[3].x = ortest_pkg::AW'($signed(cur[ortest_pkg::RB_X]))
                - ortest_pkg::AW'($signed(cur[ortest_pkg::RT_X]));
        ax[3].y = ortest_pkg::AW'($signed(cur[ortest_pkg::RB_Y]))
                - ortest_pkg::AW'($signed(cur[ortest_pkg::RT_Y]));
    end

    always_comb begin
        en_l[ortest_pkg::NLS-1] = !r_vl[ortest_pkg::NLS-1] || take;
        for (int i = ortest_pkg::NLS - 2; i >= 0; i--) begin
            en_l[i] = !r_vl[i] || en_l[i+1];
        end
        en_a = !r_va || en_l[0];
    end

    assign o_s_axis_tready = en_a;
    assign accept          = i_s_axis_tvalid && en_a;
    assign ctrl.en         = en_l;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= '0;
            r_va  <= 1'b0;
            r_vl  <= '0;
        end else begin
            if (accept && !i_s_axis_tuser[0]) begin
                r_ref <= cur;
            end
            if (en_a) begin
                r_va <= accept && i_s_axis_tuser[0];
            end
            if (en_l[0]) begin
                r_vl[0] <= r_va;
            end
            for (int i = 1; i < ortest_pkg::NLS; i++) begin
                if (en_l[i]) begin
                    r_vl[i] <= r_vl[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_ref <= r_ref;
            r_a_cur <= cur;
            for (int l = 0; l < ortest_pkg::NLANE; l++) begin
                r_a_axis[l] <= ax[l];
            end
        end
    end

    for (genvar g = 0; g < ortest_pkg::NLANE; g++) begin : g_lane
        ortest_lane u_lane (
            .i_clk  (i_clk),
            .i_ctrl (ctrl),
            .i_ref  (r_a_ref),
            .i_cur  (r_a_cur),
            .i_axis (r_a_axis[g]),
            .o_hit  (lane_hit[g])
        );
    end

    ortest_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_vl[ortest_pkg::NLS-1]),
        .i_hits     (lane_hit),
        .i_m_tready (i_m_axis_tready),
        .o_take     (take),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_m_tdata  (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

// ----- hdl/ortest_lane.sv -----
// ---------------------------------------------------------------------------
// Oriented rectangle overlap test: axis lane
// Projects both rectangles onto one axis and checks strict interval overlap.
// ---------------------------------------------------------------------------
`default_nettype none

module ortest_lane (
    input  wire logic                   i_clk,
    input  wire ortest_pkg::t_lane_ctrl i_ctrl,
    input  wire ortest_pkg::t_rect      i_ref,
    input  wire ortest_pkg::t_rect      i_cur,
    input  wire ortest_pkg::t_axis      i_axis,
    output logic                        o_hit
);

    ortest_pkg::t_rect rs [2];

    logic signed [ortest_pkg::PW-1:0] r_px  [2][4];
    logic signed [ortest_pkg::PW-1:0] r_py  [2][4];
    logic signed [ortest_pkg::DW-1:0] r_dot [2][4];
    logic signed [ortest_pkg::DW-1:0] r_lo  [2][2];
    logic signed [ortest_pkg::DW-1:0] r_hi  [2][2];
    logic signed [ortest_pkg::DW-1:0] r_min [2];
    logic signed [ortest_pkg::DW-1:0] r_max [2];
    logic                             r_hit;

    assign rs[0] = i_ref;
    assign rs[1] = i_cur;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[ortest_pkg::ST_MUL]) begin
            for (int r = 0; r < 2; r++) begin
                for (int k = 0; k < 4; k++) begin
                    r_px[r][k] <= ortest_pkg::PW'($signed(rs[r][2*k]))
                                * ortest_pkg::PW'(i_axis.x);
                    r_py[r][k] <= ortest_pkg::PW'($signed(rs[r][2*k+1]))
                                * ortest_pkg::PW'(i_axis.y);
                end
            end
        end
        if (i_ctrl.en[ortest_pkg::ST_DOT]) begin
            for (int r = 0; r < 2; r++) begin
                for (int k = 0; k < 4; k++) begin
                    r_dot[r][k] <= ortest_pkg::DW'(r_px[r][k]) + ortest_pkg::DW'(r_py[r][k]);
                end
            end
        end
        if (i_ctrl.en[ortest_pkg::ST_PAIR]) begin
            for (int r = 0; r < 2; r++) begin
                for (int p = 0; p < 2; p++) begin
                    r_lo[r][p] <= (r_dot[r][2*p] < r_dot[r][2*p+1]) ?
                                  r_dot[r][2*p] : r_dot[r][2*p+1];
                    r_hi[r][p] <= (r_dot[r][2*p] < r_dot[r][2*p+1]) ?
                                  r_dot[r][2*p+1] : r_dot[r][2*p];
                end
            end
        end
        if (i_ctrl.en[ortest_pkg::ST_RED]) begin
            for (int r = 0; r < 2; r++) begin
                r_min[r] <= (r_lo[r][0] < r_lo[r][1]) ? r_lo[r][0] : r_lo[r][1];
                r_max[r] <= (r_hi[r][0] < r_hi[r][1]) ? r_hi[r][1] : r_hi[r][0];
            end
        end
        if (i_ctrl.en[ortest_pkg::ST_CMP]) begin
            r_hit <= (r_min[0] < r_max[1]) && (r_min[1] < r_max[0]);
        end
    end

    assign o_hit = r_hit;

endmodule

`default_nettype wire

// ----- hdl/ortest_merge.sv -----
// ---------------------------------------------------------------------------
// Oriented rectangle overlap test: lane merge and output register
// Combines the four axis results and holds the result until it is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module ortest_merge (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    input  wire logic [ortest_pkg::NLANE-1:0]     i_hits,
    input  wire logic                             i_m_tready,
    output logic                                  o_take,
    output logic                                  o_m_tvalid,
    output logic [ortest_pkg::OTW-1:0]            o_m_tdata
);

    logic r_valid;
    logic r_hit;

    assign o_take = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
        if (o_take) begin
            r_hit <= &i_hits;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {{(ortest_pkg::OTW-1){1'b0}}, r_hit};

endmodule

`default_nettype wire
